/* rtl/rhc_pkg.sv */
package rhc_pkg;

  // Integer part of the hue word: 0 .. 359 degrees.
  localparam int HUE_INT_BITS = 9;

  // Degrees covered by one hue sector.
  localparam int DEG_PER_SECTOR = 60;

  // Which channel is largest, red taking ties over green, green over blue.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

/* rtl/rhc_front.sv */
// Front stage: max/min, chroma, sector numerator and the dividends and
// divisors handed to the divider cells.
module rhc_front import rhc_pkg::*; #(
  parameter int W   = 8,
  parameter int HFB = 6,
  parameter int L   = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [W-1:0]       red_in,
  input  logic [W-1:0]       green_in,
  input  logic [W-1:0]       blue_in,
  input  logic [W-1:0]       alpha_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [W-1:0]       hue_rem,
  output logic [L-1:0]       hue_low,
  output logic [W-1:0]       hue_den,
  output logic [W:0]         sat_rem,
  output logic [L-1:0]       sat_low,
  output logic [W:0]         sat_den,
  output logic [W-1:0]       value,
  output logic [W-1:0]       alpha
);

  localparam int NW = W + 3;

  logic [W-1:0]     hi, lo, chroma;
  logic             gray;
  sector_t          sector;
  logic [NW-1:0]    num;
  logic [L+W-1:0]   hue_div;
  logic [2*W-1:0]   fc;
  logic [L+W:0]     sat_div;
  logic             load;

  always_comb begin
    hi = red_in;
    lo = red_in;
    if (green_in > hi) hi = green_in;
    if (blue_in > hi) hi = blue_in;
    if (green_in < lo) lo = green_in;
    if (blue_in < lo) lo = blue_in;
    chroma = hi - lo;
    gray = (chroma == '0);

    if (red_in == hi) sector = SECT_RED;
    else if (green_in == hi) sector = SECT_GREEN;
    else sector = SECT_BLUE;

    // Modular arithmetic in NW bits; the true result is always 0 .. 6C-1.
    case (sector)
      SECT_RED: begin
        if (green_in >= blue_in) num = NW'(green_in) - NW'(blue_in);
        else num = NW'(6) * NW'(chroma) - (NW'(blue_in) - NW'(green_in));
      end
      SECT_GREEN: num = NW'(2) * NW'(chroma) + NW'(blue_in) - NW'(red_in);
      SECT_BLUE:  num = NW'(4) * NW'(chroma) + NW'(red_in) - NW'(green_in);
      default:    num = '0;
    endcase

    // Gray pixel: zero dividend over a nonzero divisor gives zero quotients.
    hue_div = gray ? '0
                   : ((L+W)'(num) * (L+W)'(DEG_PER_SECTOR)) << HFB;
    // F*C = (C << W) - C, then 2FC + V.
    fc = {chroma, {W{1'b0}}} - (2*W)'(chroma);
    sat_div = gray ? '0 : ((L+W+1)'({fc, 1'b0}) + (L+W+1)'(hi));
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      hue_rem <= hue_div[L+W-1:L];
      hue_low <= hue_div[L-1:0];
      hue_den <= gray ? W'(1) : chroma;
      sat_rem <= sat_div[L+W:L];
      sat_low <= sat_div[L-1:0];
      // black has V = 0, so gray pixels divide by one instead
      sat_den <= gray ? (W+1)'(1) : {hi, 1'b0};
      value   <= hi;
      alpha   <= alpha_in;
    end
  end

endmodule

/* rtl/rhc_cell.sv */
// One restoring-division step for both the hue and saturation quotients.
// The low word shifts dividend bits out at the top and quotient bits in at
// the bottom; after L cells it holds the full quotient.
module rhc_cell #(
  parameter int W = 8,
  parameter int L = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] hue_rem_in,
  input  logic [L-1:0] hue_low_in,
  input  logic [W-1:0] hue_den_in,
  input  logic [W:0]   sat_rem_in,
  input  logic [L-1:0] sat_low_in,
  input  logic [W:0]   sat_den_in,
  input  logic [W-1:0] value_in,
  input  logic [W-1:0] alpha_in,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] hue_rem,
  output logic [L-1:0] hue_low,
  output logic [W-1:0] hue_den,
  output logic [W:0]   sat_rem,
  output logic [L-1:0] sat_low,
  output logic [W:0]   sat_den,
  output logic [W-1:0] value,
  output logic [W-1:0] alpha
);

  logic [W:0]   hue_trial;
  logic [W+1:0] sat_trial;
  logic         hue_bit, sat_bit;
  logic [W-1:0] hue_rem_next;
  logic [W:0]   sat_rem_next;
  logic         load;

  always_comb begin
    hue_trial = {hue_rem_in, hue_low_in[L-1]};
    hue_bit   = (hue_trial >= {1'b0, hue_den_in});
    hue_rem_next = hue_bit ? W'(hue_trial - {1'b0, hue_den_in}) : hue_trial[W-1:0];

    sat_trial = {sat_rem_in, sat_low_in[L-1]};
    sat_bit   = (sat_trial >= {1'b0, sat_den_in});
    sat_rem_next = sat_bit ? (W+1)'(sat_trial - {1'b0, sat_den_in}) : sat_trial[W:0];
  end

  assign load     = !out_valid || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      hue_rem <= hue_rem_next;
      hue_low <= {hue_low_in[L-2:0], hue_bit};
      hue_den <= hue_den_in;
      sat_rem <= sat_rem_next;
      sat_low <= {sat_low_in[L-2:0], sat_bit};
      sat_den <= sat_den_in;
      value   <= value_in;
      alpha   <= alpha_in;
    end
  end

endmodule

/* rtl/rgb_to_hsv_converter_top.sv */
// RGB to HSV pixel converter. Each request carries one pixel of red, green,
// blue and alpha (CHANNEL_BITS each) and yields one HSV pixel: value is the
// largest color channel, hue is in degrees times 2^HUE_FRACTION_BITS
// (truncated, 0 .. 360*2^HUE_FRACTION_BITS - 1), saturation is
// full_scale*chroma/value rounded half up, and alpha passes through. Gray
// pixels give zero hue and saturation; on ties for largest, red beats green
// and green beats blue. Throughput is one pixel per clock while out_ready is
// held high. The pipeline is one front stage plus a row of L divider cells,
// with L = max(9 + HUE_FRACTION_BITS, CHANNEL_BITS), each cell producing
// one quotient bit of both the hue and the saturation division.
// Every stage has its own valid bit, so bubbles close up, and input is still
// taken while a finished pixel waits at the output as long as some stage in
// the row is empty.
module rgb_to_hsv_converter_top import rhc_pkg::*; #(
  parameter int CHANNEL_BITS      = 8,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [CHANNEL_BITS-1:0]                   red_in,
  input  logic [CHANNEL_BITS-1:0]                   green_in,
  input  logic [CHANNEL_BITS-1:0]                   blue_in,
  input  logic [CHANNEL_BITS-1:0]                   alpha_in,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0] hue_out,
  output logic [CHANNEL_BITS-1:0]                   saturation_out,
  output logic [CHANNEL_BITS-1:0]                   value_out,
  output logic [CHANNEL_BITS-1:0]                   alpha_out
);

  localparam int W  = CHANNEL_BITS;
  localparam int QH = HUE_INT_BITS + HUE_FRACTION_BITS;
  // Both quotients run over the same number of steps; the shorter one just
  // picks up leading zero bits.
  localparam int L  = (QH > W) ? QH : W;

  // Index 0 is the front stage output, index L the last cell.
  logic         v   [0:L];
  logic         rdy [0:L];
  logic [W-1:0] hrem [0:L];
  logic [L-1:0] hlow [0:L];
  logic [W-1:0] hden [0:L];
  logic [W:0]   srem [0:L];
  logic [L-1:0] slow [0:L];
  logic [W:0]   sden [0:L];
  logic [W-1:0] val  [0:L];
  logic [W-1:0] alp  [0:L];

  rhc_front #(
    .W   (W),
    .HFB (HUE_FRACTION_BITS),
    .L   (L)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .hue_rem   (hrem[0]),
    .hue_low   (hlow[0]),
    .hue_den   (hden[0]),
    .sat_rem   (srem[0]),
    .sat_low   (slow[0]),
    .sat_den   (sden[0]),
    .value     (val[0]),
    .alpha     (alp[0])
  );

  // Row of divider cells, one quotient bit per cell.
  for (genvar i = 0; i < L; i++) begin : g_cell
    rhc_cell #(
      .W (W),
      .L (L)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (v[i]),
      .in_ready   (rdy[i]),
      .hue_rem_in (hrem[i]),
      .hue_low_in (hlow[i]),
      .hue_den_in (hden[i]),
      .sat_rem_in (srem[i]),
      .sat_low_in (slow[i]),
      .sat_den_in (sden[i]),
      .value_in   (val[i]),
      .alpha_in   (alp[i]),
      .out_valid  (v[i+1]),
      .out_ready  (rdy[i+1]),
      .hue_rem    (hrem[i+1]),
      .hue_low    (hlow[i+1]),
      .hue_den    (hden[i+1]),
      .sat_rem    (srem[i+1]),
      .sat_low    (slow[i+1]),
      .sat_den    (sden[i+1]),
      .value      (val[i+1]),
      .alpha      (alp[i+1])
    );
  end

  // The last cell's registers are the output register.
  assign rdy[L]         = out_ready;
  assign out_valid      = v[L];
  assign hue_out        = hlow[L][QH-1:0];
  assign saturation_out = slow[L][W-1:0];
  assign value_out      = val[L];
  assign alpha_out      = alp[L];

endmodule
